// ----- hw/rtl/ghal_pkg.sv -----
// shared types and constants of the generational handle allocator
package ghal_pkg;

  localparam int unsigned Slots   = 256;
  localparam int unsigned SlotAw  = $clog2(Slots);
  localparam int unsigned CountW  = SlotAw + 1;
  localparam int unsigned TagW    = 32;
  localparam int unsigned IdxW    = 32;
  localparam int unsigned OutIdxW = 8;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [FuncW-1:0] {
    FuncCreate = 2'd0,
    FuncLookup = 2'd1,
    FuncRemove = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StBad  = 2'd2
  } status_e;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SlotAw-1:0] push_idx;
  } stack_ctl_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SlotAw-1:0] top;
  } stack_sts_t;

  typedef struct packed {
    logic              we;
    logic [SlotAw-1:0] addr;
    logic [TagW-1:0]   data;
  } tag_wr_t;

endpackage

// ----- hw/rtl/ghal_ram.sv -----
// generic single-write, single-read ram with registered read data
module ghal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ghal_stack.sv -----
// lifo free stack of slot indices with a prefetched top entry
module ghal_stack
  import ghal_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stack_ctl_t ctl_i,
  output stack_sts_t sts_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              fwd_q;
  logic [SlotAw-1:0] fwd_idx_q;
  logic [SlotAw-1:0] raddr;
  logic [SlotAw-1:0] rdata;

  always_comb begin
    count_d = count_q;
    if (ctl_i.push) begin
      count_d = count_q + CountW'(1);
    end else if (ctl_i.pop) begin
      count_d = count_q - CountW'(1);
    end
  end

  // always fetch the entry that is top after this cycle's update
  assign raddr = SlotAw'(count_d - CountW'(1));

  ghal_ram #(
    .Width (SlotAw),
    .Depth (Slots)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (count_q[SlotAw-1:0]),
    .wdata_i (ctl_i.push_idx),
    .re_i    (1'b1),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // a push collides with the fetch of the same entry, so bypass it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      fwd_q   <= ctl_i.push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      fwd_idx_q <= ctl_i.push_idx;
    end
  end

  assign sts_o.count = count_q;
  assign sts_o.top   = fwd_q ? fwd_idx_q : rdata;

endmodule

// ----- hw/rtl/ghal_tags.sv -----
// slot tag store with bypass of the most recent write
module ghal_tags
  import ghal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  logic [SlotAw-1:0] raddr_i,
  input  tag_wr_t           wr_i,
  output logic [TagW-1:0]   rdata_o
);

  logic [TagW-1:0]   ram_rdata;
  logic [SlotAw-1:0] raddr_q;
  logic              lw_valid_q;
  logic [SlotAw-1:0] lw_addr_q;
  logic [TagW-1:0]   lw_data_q;

  ghal_ram #(
    .Width (TagW),
    .Depth (Slots)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.we),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (wr_i.we) begin
      lw_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      raddr_q <= raddr_i;
    end
    if (wr_i.we) begin
      lw_addr_q <= wr_i.addr;
      lw_data_q <= wr_i.data;
    end
  end

  // last write always matches memory contents, or is newer than the read
  assign rdata_o = (lw_valid_q && (lw_addr_q == raddr_q)) ? lw_data_q : ram_rdata;

endmodule

// ----- hw/rtl/generational_handle_allocator.sv -----
// top level of the generational handle allocator
//
// requests enter on the s_axis channel: tuser carries the operation
// (create, lookup, remove), tdata the handle (slot index and tag)
// results leave on the m_axis channel: tuser carries the status
// (ok, table full, handle not valid), tdata the slot index and tag
// every request word yields exactly one result word, in order
// a word accepted into the request stage is processed there once the
// result register is free or draining, and its result is held there
// throughput: one word per cycle while the receiver does not stall; the tag
// ram read is issued at accept and the free stack top is prefetched, so
// the single processing stage does not wait for either
// reset empties the table: no slot in use, empty free stack, next tag 1;
// the tag and stack rams are not cleared, no slot is read before written
// when the receiver stalls the result register holds, the request stage
// keeps its word, and s_axis_tready drops once both are occupied
module generational_handle_allocator
  import ghal_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] hdl_slot, [63:32] handle_tag
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [FuncW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] out_index, [39:8] out_tag
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [StatusW-1:0]  m_axis_tuser
);

  // request stage
  logic             s1_valid_q;
  logic [FuncW-1:0] s1_func_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [TagW-1:0]  s1_tag_q;

  // result register
  logic               out_valid_q;
  status_e            out_status_q, out_status_d;
  logic [OutIdxW-1:0] out_index_q, out_index_d;
  logic [TagW-1:0]    out_tag_q, out_tag_d;

  // allocator state
  logic [CountW-1:0] used_len_q, used_len_d;
  logic [TagW-1:0]   next_tag_q, next_tag_d, tag_inc;

  logic            accept;
  logic            fire;
  logic [TagW-1:0] stored_tag;
  logic            in_range;
  logic            handle_ok;
  stack_ctl_t      stack_ctl;
  stack_sts_t      stack_sts;
  tag_wr_t         tag_wr;

  // processing happens when the result register is free or being drained
  assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q <= s_axis_tuser;
      s1_idx_q  <= s_axis_tdata[IdxW-1:0];
      s1_tag_q  <= s_axis_tdata[IdxW+TagW-1:IdxW];
    end
  end

  // tag lookup starts together with the accept
  ghal_tags u_tags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[SlotAw-1:0]),
    .wr_i    (tag_wr),
    .rdata_o (stored_tag)
  );

  ghal_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (stack_ctl),
    .sts_o  (stack_sts)
  );

  // handle is valid below the high-water mark, with a nonzero matching tag
  assign in_range  = (s1_idx_q[IdxW-1:CountW] == '0) &&
                     (s1_idx_q[CountW-1:0] < used_len_q);
  assign handle_ok = (s1_tag_q != '0) && in_range && (stored_tag == s1_tag_q);

  // tag counter skips zero on wrap
  assign tag_inc = next_tag_q + TagW'(1);

  always_comb begin
    stack_ctl    = '0;
    tag_wr       = '0;
    used_len_d   = used_len_q;
    next_tag_d   = next_tag_q;
    out_status_d = StBad;
    out_index_d  = '0;
    out_tag_d    = '0;
    if (fire) begin
      case (func_e'(s1_func_q))
        FuncCreate: begin
          if ((stack_sts.count != '0) || (used_len_q < CountW'(Slots))) begin
            if (stack_sts.count != '0) begin
              // reuse the most recently freed slot
              stack_ctl.pop = 1'b1;
              tag_wr.addr   = stack_sts.top;
            end else begin
              // take the next never-used slot
              tag_wr.addr = used_len_q[SlotAw-1:0];
              used_len_d  = used_len_q + CountW'(1);
            end
            tag_wr.we    = 1'b1;
            tag_wr.data  = next_tag_q;
            next_tag_d   = (tag_inc == '0) ? TagW'(1) : tag_inc;
            out_status_d = StOk;
            out_index_d  = OutIdxW'(tag_wr.addr);
            out_tag_d    = next_tag_q;
          end else begin
            out_status_d = StFull;
          end
        end
        FuncLookup: begin
          if (handle_ok) begin
            out_status_d = StOk;
            out_index_d  = s1_idx_q[OutIdxW-1:0];
          end
        end
        FuncRemove: begin
          if (handle_ok && (stack_sts.count < CountW'(Slots))) begin
            // retire the slot and push it for reuse
            tag_wr.we          = 1'b1;
            tag_wr.addr        = s1_idx_q[SlotAw-1:0];
            tag_wr.data        = '0;
            stack_ctl.push     = 1'b1;
            stack_ctl.push_idx = s1_idx_q[SlotAw-1:0];
            out_status_d       = StOk;
            out_index_d        = s1_idx_q[OutIdxW-1:0];
          end
        end
        default: begin
          out_status_d = StBad;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      used_len_q  <= '0;
      next_tag_q  <= TagW'(1);
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      used_len_q <= used_len_d;
      next_tag_q <= next_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= out_status_d;
      out_index_q  <= out_index_d;
      out_tag_q    <= out_tag_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_tag_q, out_index_q};

`ifndef NO_ASSERTIONS
  a_tag_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_tag_q != '0)
    else $error("next tag became zero");

  a_stack_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stack_sts.count <= used_len_q) && (used_len_q <= CountW'(Slots)))
    else $error("free stack deeper than high-water mark");

  a_full_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == StFull)) |->
      ((used_len_q == CountW'(Slots)) && (stack_sts.count == '0)))
    else $error("full reported while a slot is free");

  a_fire_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed request produced no result");
`endif

endmodule
